### hw/rtl/slr_pkg.sv
// Shared types and constants for the styled line rasterizer.
`default_nettype none

package slr_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned COORD_BITS_DEF     = 11;
  localparam int unsigned PATTERN_PERIOD_DEF = 4;

  // Line style register codes.
  typedef enum logic [1:0] {
    STYLE_SIMPLE = 2'd0,
    STYLE_DOTTED = 2'd1,
    STYLE_DASHED = 2'd2,
    STYLE_SOLID  = 2'd3
  } style_t;

  // Input item kinds carried on the slave tuser bit.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Output tuser bit positions.
  localparam int unsigned OUT_USER_BITS = 2;
  localparam int unsigned USER_DRAWN    = 0;
  localparam int unsigned USER_THICK    = 1;

endpackage

`default_nettype wire

### hw/rtl/styled_line_rasterizer_unit.sv
// Bresenham line stepper with line styles; top level of the rasterizer.
// A pixel item is registered and appears on the master side in the cycle after its advance item is taken.
// Throughput: one item per clock unless a waiting pixel is not taken; the error-term update is combinational.
// A waiting pixel holds the input off unless the master side takes it in the same cycle.
// Reset (rst, synchronous): the line goes idle, the style becomes simple, the output empties.
// A load item gives no pixel; an advance item while idle gives none either.
`default_nettype none

module styled_line_rasterizer_unit #(
  parameter int unsigned COORD_BITS     = slr_pkg::COORD_BITS_DEF,
  parameter int unsigned PATTERN_PERIOD = slr_pkg::PATTERN_PERIOD_DEF,
  localparam int unsigned IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration write channel: line style.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire slr_pkg::style_t                   cfg_data,
  // Input items.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: start_x, start_y, end_x, end_y from the lowest bit up, zero padded.
  input  wire logic [IN_DATA_BITS-1:0]           s_axis_tdata,
  // tuser: mode.
  input  wire logic                              s_axis_tuser,
  // Result items.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: pixel_x, pixel_y from the lowest bit up, zero padded.
  output logic [OUT_DATA_BITS-1:0]               m_axis_tdata,
  // tuser: drawn, thick from the lowest bit up.
  output logic [slr_pkg::OUT_USER_BITS-1:0]      m_axis_tuser,
  output logic                                   m_axis_tlast
);

  import slr_pkg::*;

  localparam int unsigned ERR_BITS = COORD_BITS + 3;
  localparam int unsigned CNT_BITS = $clog2(PATTERN_PERIOD);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(PATTERN_PERIOD - 1);

  // Line state.
  style_t                        line_style;
  logic signed [COORD_BITS-1:0]  cur_x, cur_y, target_x, target_y;
  logic        [COORD_BITS-1:0]  major_delta, minor_delta;
  logic signed [ERR_BITS-1:0]    error_term;
  logic                          step_neg_x, step_neg_y, steep, active;
  logic        [CNT_BITS-1:0]    pattern_count;

  // Output register.
  logic                          out_valid;
  logic signed [COORD_BITS-1:0]  out_x, out_y;
  logic                          out_drawn, out_thick, out_last;

  // Next values.
  logic signed [COORD_BITS-1:0]  cur_x_next, cur_y_next, target_x_next, target_y_next;
  logic        [COORD_BITS-1:0]  major_delta_next, minor_delta_next;
  logic signed [ERR_BITS-1:0]    error_term_next;
  logic                          step_neg_x_next, step_neg_y_next, steep_next, active_next;
  logic        [CNT_BITS-1:0]    pattern_count_next;
  logic                          emit;
  logic signed [COORD_BITS-1:0]  emit_x, emit_y;
  logic                          emit_drawn, emit_last;

  logic                          in_fire;
  logic                          at_end;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign at_end        = steep ? (cur_y == target_y) : (cur_x == target_x);

  // Load setup, the endpoint pixel, or one Bresenham step.
  always_comb begin
    logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
    logic signed [COORD_BITS:0]   diff_x, diff_y;
    logic        [COORD_BITS-1:0] dx, dy, maj, mnr;
    logic signed [ERR_BITS-1:0]   two_major, two_minor;
    logic signed [COORD_BITS-1:0] step_x, step_y;
    logic                         err_pos;

    sx = s_axis_tdata[COORD_BITS-1:0];
    sy = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    ex = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    ey = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
    diff_x = {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
    diff_y = {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};
    dx = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    dy = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    maj = (dy > dx) ? dy : dx;
    mnr = (dy > dx) ? dx : dy;

    two_major = $signed({2'b00, major_delta, 1'b0});
    two_minor = $signed({2'b00, minor_delta, 1'b0});
    step_x    = step_neg_x ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    step_y    = step_neg_y ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    err_pos   = !error_term[ERR_BITS-1];

    cur_x_next         = cur_x;
    cur_y_next         = cur_y;
    target_x_next      = target_x;
    target_y_next      = target_y;
    major_delta_next   = major_delta;
    minor_delta_next   = minor_delta;
    error_term_next    = error_term;
    step_neg_x_next    = step_neg_x;
    step_neg_y_next    = step_neg_y;
    steep_next         = steep;
    active_next        = active;
    pattern_count_next = pattern_count;
    emit               = 1'b0;
    emit_x             = cur_x;
    emit_y             = cur_y;
    emit_drawn         = 1'b1;
    emit_last          = 1'b0;

    if (s_axis_tuser == MODE_LOAD) begin
      cur_x_next         = sx;
      cur_y_next         = sy;
      target_x_next      = ex;
      target_y_next      = ey;
      major_delta_next   = maj;
      minor_delta_next   = mnr;
      error_term_next    = $signed({2'b00, mnr, 1'b0}) - $signed({3'b000, maj});
      step_neg_x_next    = !(diff_x > 0);
      step_neg_y_next    = !(diff_y > 0);
      steep_next         = dy > dx;
      pattern_count_next = '0;
      active_next        = 1'b1;
    end else if (active && at_end) begin
      // Endpoint: always drawn, closes the line.
      emit        = 1'b1;
      emit_x      = target_x;
      emit_y      = target_y;
      emit_last   = 1'b1;
      active_next = 1'b0;
    end else if (active) begin
      emit = 1'b1;
      case (line_style)
        STYLE_DOTTED: emit_drawn = (pattern_count == '0);
        STYLE_DASHED: emit_drawn = (pattern_count != '0);
        default:      emit_drawn = 1'b1;
      endcase
      if (steep) begin
        cur_y_next = cur_y + step_y;
        if (err_pos) begin
          cur_x_next = cur_x + step_x;
        end
      end else begin
        cur_x_next = cur_x + step_x;
        if (err_pos) begin
          cur_y_next = cur_y + step_y;
        end
      end
      error_term_next    = error_term - (err_pos ? two_major : '0) + two_minor;
      pattern_count_next = (pattern_count == CNT_LAST) ? '0 : pattern_count + 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_style    <= STYLE_SIMPLE;
      active        <= 1'b0;
      pattern_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_style <= cfg_data;
      end
      if (in_fire) begin
        active        <= active_next;
        pattern_count <= pattern_count_next;
        out_valid     <= emit;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Line geometry and output payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      error_term  <= '0;
      step_neg_x  <= 1'b0;
      step_neg_y  <= 1'b0;
      steep       <= 1'b0;
    end else if (in_fire) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      target_x    <= target_x_next;
      target_y    <= target_y_next;
      major_delta <= major_delta_next;
      minor_delta <= minor_delta_next;
      error_term  <= error_term_next;
      step_neg_x  <= step_neg_x_next;
      step_neg_y  <= step_neg_y_next;
      steep       <= steep_next;
    end
    if (in_fire && emit) begin
      out_x     <= emit_x;
      out_y     <= emit_y;
      out_drawn <= emit_drawn;
      out_thick <= (line_style == STYLE_SOLID);
      out_last  <= emit_last;
    end
  end

  assign m_axis_tvalid            = out_valid;
  assign m_axis_tdata             = OUT_DATA_BITS'({out_y, out_x});
  assign m_axis_tuser[USER_DRAWN] = out_drawn;
  assign m_axis_tuser[USER_THICK] = out_thick;
  assign m_axis_tlast             = out_last;

  // A load always starts a fresh line with the pattern at its beginning.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_axis_tuser == MODE_LOAD) |=> (active && pattern_count == '0))
    else $error("load did not start a line");

  // Giving the endpoint ends the line.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_axis_tuser == MODE_ADVANCE && active && at_end) |=>
      (!active && out_valid && out_last))
    else $error("endpoint did not close the line");

  // The endpoint pixel is drawn in every style.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> out_drawn)
    else $error("endpoint pixel not drawn");

  // An advance while idle leaves no pixel behind.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_axis_tuser == MODE_ADVANCE && !active) |=> !out_valid)
    else $error("pixel given while idle");

endmodule

`default_nettype wire
